FILE: rtl/core/asmtok_pkg.sv
`timescale 1ns / 1ps
// Shared types, codes and character classes of the assembler source tokenizer.
// Depends on nothing; the front, back and top-level files import it.
package asmtok_pkg;

   localparam int LINE_BITS_DEF   = 20;
   localparam int COLUMN_BITS_DEF = 16;
   localparam int QUEUE_DEPTH     = 4;

   typedef enum logic [3:0] {
      KIND_NONE      = 4'd0,
      KIND_EOL       = 4'd1,
      KIND_COMMA     = 4'd2,
      KIND_ADD       = 4'd3,
      KIND_SUB       = 4'd4,
      KIND_INDIRECT  = 4'd5,
      KIND_COLON     = 4'd6,
      KIND_HEX       = 4'd7,
      KIND_DEC       = 4'd8,
      KIND_FLOAT     = 4'd9,
      KIND_IDENT     = 4'd10,
      KIND_DIRECTIVE = 4'd11,
      KIND_STRING    = 4'd12,
      KIND_CHAR      = 4'd13
   } kind_type;

   typedef enum logic [2:0] {
      ERR_NONE       = 3'd0,
      ERR_CONTINUE   = 3'd1,
      ERR_SECOND_DOT = 3'd2,
      ERR_EMPTY_DIR  = 3'd3,
      ERR_UNTERM     = 3'd4,
      ERR_EMPTY_CHAR = 3'd5,
      ERR_UNEXPECTED = 3'd6
   } err_type;

   typedef struct packed {
      kind_type   kind;
      logic [7:0] text_byte;
      logic       byte_valid;
      logic       token_start;
      logic       token_end;
      err_type    error;
   } tok_item_type;

   typedef struct packed {
      logic push;
      logic pair;
   } tok_push_type;

   localparam logic [7:0] CH_TAB    = 8'h09;
   localparam logic [7:0] CH_LF     = 8'h0A;
   localparam logic [7:0] CH_CR     = 8'h0D;
   localparam logic [7:0] CH_SPACE  = 8'h20;
   localparam logic [7:0] CH_DQUOTE = 8'h22;
   localparam logic [7:0] CH_DOLLAR = 8'h24;
   localparam logic [7:0] CH_SQUOTE = 8'h27;
   localparam logic [7:0] CH_STAR   = 8'h2A;
   localparam logic [7:0] CH_PLUS   = 8'h2B;
   localparam logic [7:0] CH_COMMA  = 8'h2C;
   localparam logic [7:0] CH_MINUS  = 8'h2D;
   localparam logic [7:0] CH_DOT    = 8'h2E;
   localparam logic [7:0] CH_COLON  = 8'h3A;
   localparam logic [7:0] CH_SEMI   = 8'h3B;
   localparam logic [7:0] CH_BSL    = 8'h5C;
   localparam logic [7:0] CH_UNDER  = 8'h5F;

   function automatic logic is_digit(logic [7:0] c);
      return (c >= 8'h30) && (c <= 8'h39);
   endfunction

   function automatic logic is_alpha(logic [7:0] c);
      return ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A));
   endfunction

   function automatic logic is_word(logic [7:0] c);
      return is_digit(c) || is_alpha(c) || (c == CH_UNDER);
   endfunction

   function automatic logic is_hex(logic [7:0] c);
      return is_digit(c) || ((c >= 8'h61) && (c <= 8'h66)) || ((c >= 8'h41) && (c <= 8'h46));
   endfunction

   function automatic logic is_blank(logic [7:0] c);
      return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
   endfunction

   function automatic tok_item_type mk_item(kind_type k, logic [7:0] tb, logic bv,
                                            logic st, logic en, err_type e);
      tok_item_type r;
      r.kind        = k;
      r.text_byte   = tb;
      r.byte_valid  = bv;
      r.token_start = st;
      r.token_end   = en;
      r.error       = e;
      return r;
   endfunction

endpackage

FILE: rtl/core/asmtok_chan_if.sv
`timescale 1ns / 1ps
// Valid/ready channels of the tokenizer: source bytes in, token words out.
// Depends on nothing but the widths handed in as parameters.
interface asmtok_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] byte_req;
   logic       end_of_text;

   modport source (output valid, output byte_req, output end_of_text, input ready);
   modport sink   (input valid, input byte_req, input end_of_text, output ready);
endinterface

interface asmtok_rsp_if #(
   parameter int LINE_BITS   = 20,
   parameter int COLUMN_BITS = 16
);
   logic                   valid;
   logic                   ready;
   logic [3:0]             kind;
   logic [7:0]             text_byte;
   logic                   byte_valid;
   logic                   token_start;
   logic                   token_end;
   logic [LINE_BITS-1:0]   line;
   logic [COLUMN_BITS-1:0] column;
   logic [2:0]             error;
   logic                   last_of_run;

   modport source (output valid, output kind, output text_byte, output byte_valid,
                   output token_start, output token_end, output line, output column,
                   output error, output last_of_run, input ready);
   modport sink   (input valid, input kind, input text_byte, input byte_valid,
                   input token_start, input token_end, input line, input column,
                   input error, input last_of_run, output ready);
endinterface

FILE: rtl/core/asmtok_front.sv
`timescale 1ns / 1ps
// Lexer front: takes one source byte per cycle while the queue has room, tracks
// position and mode, and pushes the words, up to two, that each byte causes. Depends on asmtok_pkg.
module asmtok_front #(
   parameter int LINE_BITS   = asmtok_pkg::LINE_BITS_DEF,
   parameter int COLUMN_BITS = asmtok_pkg::COLUMN_BITS_DEF
) (
   input  logic                     clock,
   input  logic                     reset,
   asmtok_req_if.sink               req_ch,
   input  logic                     q_ready,
   output asmtok_pkg::tok_push_type push,
   output asmtok_pkg::tok_item_type item [2],
   output logic [LINE_BITS-1:0]     item_line [2],
   output logic [COLUMN_BITS-1:0]   item_col [2]
);
   import asmtok_pkg::*;

   typedef enum logic [9:0] {
      M_IDLE      = 10'b0000000001,
      M_EOLRUN    = 10'b0000000010,
      M_BACKSLASH = 10'b0000000100,
      M_COMMENT   = 10'b0000001000,
      M_HEX       = 10'b0000010000,
      M_NUMBER    = 10'b0000100000,
      M_IDENT     = 10'b0001000000,
      M_DIRECTIVE = 10'b0010000000,
      M_STRING    = 10'b0100000000,
      M_CHAR      = 10'b1000000000
   } mode_type;

   mode_type               mode_ff, mode_in;
   logic [LINE_BITS-1:0]   line_ff, line_in, tokl_ff, tokl_in, ln_u;
   logic [COLUMN_BITS-1:0] col_ff, col_in, tokc_ff, tokc_in, cl_u;
   logic                   esc_ff, esc_in, dot_ff, dot_in, dote_ff, dote_in;
   logic [1:0]             tlen_ff, tlen_in;

   logic         acc, end_mark, is_nl, is_eol, do_disp;
   logic [7:0]   b;
   logic         a_v, b_v, a_tok, b_tok;
   tok_item_type a_item, b_item;

   assign acc      = req_ch.valid && req_ch.ready;
   assign b        = req_ch.byte_req;
   assign end_mark = req_ch.end_of_text || (b == 8'h00);
   assign is_nl    = (b == CH_LF);
   assign is_eol   = (b == CH_LF) || (b == CH_CR);
   assign req_ch.ready = q_ready;

   always_comb begin
      if (end_mark) begin
         ln_u = line_ff;
         cl_u = col_ff;
      end else if (is_nl) begin
         ln_u = (line_ff == '1) ? line_ff : line_ff + LINE_BITS'(1);
         cl_u = '0;
      end else begin
         ln_u = line_ff;
         cl_u = (col_ff == '1) ? col_ff : col_ff + COLUMN_BITS'(1);
      end
   end

   always_comb begin
      mode_in = mode_ff;
      line_in = ln_u;
      col_in  = cl_u;
      esc_in  = esc_ff;
      dot_in  = dot_ff;
      dote_in = dote_ff;
      tlen_in = tlen_ff;
      tokl_in = tokl_ff;
      tokc_in = tokc_ff;
      a_v     = 1'b0;
      a_tok   = 1'b1;
      a_item  = mk_item(KIND_NONE, 8'h00, 1'b0, 1'b0, 1'b0, ERR_NONE);
      b_v     = 1'b0;
      b_tok   = 1'b0;
      b_item  = mk_item(KIND_NONE, 8'h00, 1'b0, 1'b0, 1'b0, ERR_NONE);
      do_disp = 1'b0;

      if (end_mark) begin
         case (mode_ff)
            M_STRING: begin
               a_v    = 1'b1;
               a_item = mk_item(KIND_STRING, 8'h00, 1'b0, 1'b0, 1'b1, ERR_UNTERM);
            end
            M_CHAR: begin
               a_v    = 1'b1;
               a_item = mk_item(KIND_CHAR, 8'h00, 1'b0, 1'b0, 1'b1, ERR_UNTERM);
            end
            M_BACKSLASH: begin
               a_v    = 1'b1;
               a_tok  = 1'b0;
               a_item = mk_item(KIND_NONE, 8'h00, 1'b0, 1'b0, 1'b0, ERR_CONTINUE);
            end
            M_HEX: begin
               a_v    = 1'b1;
               a_item = mk_item(KIND_HEX, 8'h00, 1'b0, 1'b0, 1'b1, ERR_NONE);
            end
            M_NUMBER: begin
               a_v    = 1'b1;
               a_item = mk_item(dot_ff ? KIND_FLOAT : KIND_DEC, 8'h00, 1'b0, 1'b0, 1'b1,
                                dote_ff ? ERR_SECOND_DOT : ERR_NONE);
            end
            M_IDENT: begin
               a_v    = 1'b1;
               a_item = mk_item(KIND_IDENT, 8'h00, 1'b0, 1'b0, 1'b1, ERR_NONE);
            end
            M_DIRECTIVE: begin
               a_v    = 1'b1;
               a_item = mk_item(KIND_DIRECTIVE, 8'h00, 1'b0, 1'b0, 1'b1,
                                (tlen_ff == 2'd0) ? ERR_EMPTY_DIR : ERR_NONE);
            end
            default: begin
            end
         endcase
         b_v     = 1'b1;
         b_item  = mk_item(KIND_EOL, 8'h00, 1'b0, 1'b1, 1'b1, ERR_NONE);
         mode_in = M_IDLE;
         line_in = LINE_BITS'(1);
         col_in  = COLUMN_BITS'(1);
         esc_in  = 1'b0;
         dot_in  = 1'b0;
         dote_in = 1'b0;
         tlen_in = 2'd0;
         tokl_in = LINE_BITS'(1);
         tokc_in = COLUMN_BITS'(1);
      end else begin
         case (mode_ff)
            M_EOLRUN: do_disp = !is_eol;
            M_BACKSLASH: begin
               if (is_eol) begin
                  mode_in = M_IDLE;
               end else begin
                  a_v     = 1'b1;
                  a_tok   = 1'b0;
                  a_item  = mk_item(KIND_NONE, 8'h00, 1'b0, 1'b0, 1'b0, ERR_CONTINUE);
                  do_disp = 1'b1;
               end
            end
            M_COMMENT: do_disp = is_nl;
            M_HEX: begin
               if (is_hex(b)) begin
                  b_v    = 1'b1;
                  b_tok  = 1'b1;
                  b_item = mk_item(KIND_HEX, b, 1'b1, 1'b0, 1'b0, ERR_NONE);
               end else begin
                  a_v     = 1'b1;
                  a_item  = mk_item(KIND_HEX, 8'h00, 1'b0, 1'b0, 1'b1, ERR_NONE);
                  do_disp = 1'b1;
               end
            end
            M_NUMBER: begin
               if (is_digit(b)) begin
                  b_v    = 1'b1;
                  b_tok  = 1'b1;
                  b_item = mk_item(dot_ff ? KIND_FLOAT : KIND_DEC, b, 1'b1, 1'b0, 1'b0,
                                   ERR_NONE);
               end else if (b == CH_DOT) begin
                  b_v   = 1'b1;
                  b_tok = 1'b1;
                  if (dot_ff) begin
                     dote_in = 1'b1;
                     b_item  = mk_item(KIND_FLOAT, b, 1'b1, 1'b0, 1'b0, ERR_SECOND_DOT);
                  end else begin
                     dot_in = 1'b1;
                     b_item = mk_item(KIND_FLOAT, b, 1'b1, 1'b0, 1'b0, ERR_NONE);
                  end
               end else begin
                  a_v     = 1'b1;
                  a_item  = mk_item(dot_ff ? KIND_FLOAT : KIND_DEC, 8'h00, 1'b0, 1'b0, 1'b1,
                                    dote_ff ? ERR_SECOND_DOT : ERR_NONE);
                  do_disp = 1'b1;
               end
            end
            M_IDENT: begin
               if (is_word(b)) begin
                  b_v    = 1'b1;
                  b_tok  = 1'b1;
                  b_item = mk_item(KIND_IDENT, b, 1'b1, 1'b0, 1'b0, ERR_NONE);
               end else begin
                  a_v     = 1'b1;
                  a_item  = mk_item(KIND_IDENT, 8'h00, 1'b0, 1'b0, 1'b1, ERR_NONE);
                  do_disp = 1'b1;
               end
            end
            M_DIRECTIVE: begin
               if (is_word(b)) begin
                  tlen_in = (tlen_ff == 2'd3) ? tlen_ff : tlen_ff + 2'd1;
                  b_v     = 1'b1;
                  b_tok   = 1'b1;
                  b_item  = mk_item(KIND_DIRECTIVE, b, 1'b1, 1'b0, 1'b0, ERR_NONE);
               end else begin
                  a_v     = 1'b1;
                  a_item  = mk_item(KIND_DIRECTIVE, 8'h00, 1'b0, 1'b0, 1'b1,
                                    (tlen_ff == 2'd0) ? ERR_EMPTY_DIR : ERR_NONE);
                  do_disp = 1'b1;
               end
            end
            M_STRING, M_CHAR: begin
               b_v   = 1'b1;
               b_tok = 1'b1;
               if ((b == ((mode_ff == M_STRING) ? CH_DQUOTE : CH_SQUOTE)) && !esc_ff) begin
                  mode_in = M_IDLE;
                  if (mode_ff == M_CHAR) begin
                     b_item = mk_item(KIND_CHAR, 8'h00, 1'b0, 1'b0, 1'b1,
                                      (tlen_ff == 2'd0) ? ERR_EMPTY_CHAR : ERR_NONE);
                  end else begin
                     b_item = mk_item(KIND_STRING, 8'h00, 1'b0, 1'b0, 1'b1, ERR_NONE);
                  end
               end else begin
                  b_item  = mk_item((mode_ff == M_STRING) ? KIND_STRING : KIND_CHAR, b, 1'b1,
                                    1'b0, 1'b0, ERR_NONE);
                  tlen_in = (tlen_ff == 2'd3) ? tlen_ff : tlen_ff + 2'd1;
                  esc_in  = esc_ff ? 1'b0 : (b == CH_BSL);
               end
            end
            default: do_disp = 1'b1;
         endcase

         if (do_disp) begin
            mode_in = M_IDLE;
            b_tok   = 1'b0;
            if (is_eol) begin
               b_v     = 1'b1;
               b_item  = mk_item(KIND_EOL, 8'h00, 1'b0, 1'b1, 1'b1, ERR_NONE);
               mode_in = M_EOLRUN;
            end else if (b == CH_BSL) begin
               mode_in = M_BACKSLASH;
            end else if (b == CH_SEMI) begin
               mode_in = M_COMMENT;
            end else if (is_blank(b)) begin
               mode_in = M_IDLE;
            end else if (b == CH_COMMA) begin
               b_v    = 1'b1;
               b_item = mk_item(KIND_COMMA, 8'h00, 1'b0, 1'b1, 1'b1, ERR_NONE);
            end else if (b == CH_PLUS) begin
               b_v    = 1'b1;
               b_item = mk_item(KIND_ADD, 8'h00, 1'b0, 1'b1, 1'b1, ERR_NONE);
            end else if (b == CH_MINUS) begin
               b_v    = 1'b1;
               b_item = mk_item(KIND_SUB, 8'h00, 1'b0, 1'b1, 1'b1, ERR_NONE);
            end else if (b == CH_STAR) begin
               b_v    = 1'b1;
               b_item = mk_item(KIND_INDIRECT, 8'h00, 1'b0, 1'b1, 1'b1, ERR_NONE);
            end else if (b == CH_COLON) begin
               b_v    = 1'b1;
               b_item = mk_item(KIND_COLON, 8'h00, 1'b0, 1'b1, 1'b1, ERR_NONE);
            end else if ((b == CH_DOLLAR) || is_word(b) || (b == CH_DOT) ||
                         (b == CH_DQUOTE) || (b == CH_SQUOTE)) begin
               // open a token: position is taken after this byte
               b_v     = 1'b1;
               tokl_in = ln_u;
               tokc_in = cl_u;
               esc_in  = 1'b0;
               dot_in  = 1'b0;
               dote_in = 1'b0;
               tlen_in = 2'd0;
               if (b == CH_DOLLAR) begin
                  mode_in = M_HEX;
                  b_item  = mk_item(KIND_HEX, b, 1'b1, 1'b1, 1'b0, ERR_NONE);
               end else if (is_digit(b)) begin
                  mode_in = M_NUMBER;
                  b_item  = mk_item(KIND_DEC, b, 1'b1, 1'b1, 1'b0, ERR_NONE);
               end else if (is_word(b)) begin
                  mode_in = M_IDENT;
                  b_item  = mk_item(KIND_IDENT, b, 1'b1, 1'b1, 1'b0, ERR_NONE);
               end else if (b == CH_DOT) begin
                  mode_in = M_DIRECTIVE;
                  b_item  = mk_item(KIND_DIRECTIVE, b, 1'b1, 1'b1, 1'b0, ERR_NONE);
               end else if (b == CH_DQUOTE) begin
                  mode_in = M_STRING;
                  b_item  = mk_item(KIND_STRING, 8'h00, 1'b0, 1'b1, 1'b0, ERR_NONE);
               end else begin
                  mode_in = M_CHAR;
                  b_item  = mk_item(KIND_CHAR, 8'h00, 1'b0, 1'b1, 1'b0, ERR_NONE);
               end
            end else begin
               b_v    = 1'b1;
               b_item = mk_item(KIND_NONE, b, 1'b0, 1'b0, 1'b0, ERR_UNEXPECTED);
            end
         end
      end
   end

   // pack: the prefix word goes first when present
   always_comb begin
      push.push    = acc && (a_v || b_v);
      push.pair    = a_v && b_v;
      item[0]      = a_v ? a_item : b_item;
      item_line[0] = a_v ? (a_tok ? tokl_ff : ln_u) : (b_tok ? tokl_ff : ln_u);
      item_col[0]  = a_v ? (a_tok ? tokc_ff : cl_u) : (b_tok ? tokc_ff : cl_u);
      item[1]      = b_item;
      item_line[1] = b_tok ? tokl_ff : ln_u;
      item_col[1]  = b_tok ? tokc_ff : cl_u;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= M_IDLE;
         line_ff <= LINE_BITS'(1);
         col_ff  <= COLUMN_BITS'(1);
         esc_ff  <= 1'b0;
         dot_ff  <= 1'b0;
         dote_ff <= 1'b0;
         tlen_ff <= 2'd0;
         tokl_ff <= LINE_BITS'(1);
         tokc_ff <= COLUMN_BITS'(1);
      end else if (acc) begin
         mode_ff <= mode_in;
         line_ff <= line_in;
         col_ff  <= col_in;
         esc_ff  <= esc_in;
         dot_ff  <= dot_in;
         dote_ff <= dote_in;
         tlen_ff <= tlen_in;
         tokl_ff <= tokl_in;
         tokc_ff <= tokc_in;
      end
   end

   a_end_restarts: assert property (@(posedge clock) disable iff (reset)
      (acc && end_mark) |=> (mode_ff == M_IDLE && line_ff == LINE_BITS'(1) &&
                              col_ff == COLUMN_BITS'(1)))
      else $error("end of text did not restart the position");

   a_text_only_in_token: assert property (@(posedge clock) disable iff (reset)
      (acc && !end_mark && b_v && b_tok) |-> (mode_ff != M_IDLE && mode_ff != M_EOLRUN))
      else $error("token text word outside an open token");

   a_prefix_not_start: assert property (@(posedge clock) disable iff (reset)
      (push.push && push.pair) |-> !item[0].token_start)
      else $error("prefix word of a pair opens a token");

endmodule

FILE: rtl/core/asmtok_back.sv
`timescale 1ns / 1ps
// Result back end: short queue of word pairs from the lexer front and the
// output register that drives one word per cycle while the sink is ready. Depends on asmtok_pkg.
module asmtok_back #(
   parameter int LINE_BITS   = asmtok_pkg::LINE_BITS_DEF,
   parameter int COLUMN_BITS = asmtok_pkg::COLUMN_BITS_DEF
) (
   input  logic                     clock,
   input  logic                     reset,
   input  asmtok_pkg::tok_push_type push,
   input  asmtok_pkg::tok_item_type item [2],
   input  logic [LINE_BITS-1:0]     item_line [2],
   input  logic [COLUMN_BITS-1:0]   item_col [2],
   output logic                     q_ready,
   asmtok_rsp_if.source             rsp_ch
);
   import asmtok_pkg::*;

   localparam int PTR_BITS = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_BITS = $clog2(QUEUE_DEPTH + 1);

   typedef struct packed {
      tok_item_type           item0;
      tok_item_type           item1;
      logic [LINE_BITS-1:0]   line0;
      logic [LINE_BITS-1:0]   line1;
      logic [COLUMN_BITS-1:0] col0;
      logic [COLUMN_BITS-1:0] col1;
      logic                   pair;
   } entry_type;

   entry_type              entry_ff [QUEUE_DEPTH];
   entry_type              head;
   logic [PTR_BITS-1:0]    wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CNT_BITS-1:0]    count_ff, count_in;
   logic                   sel_ff, sel_in;
   logic                   valid_ff, valid_in;
   tok_item_type           out_item_ff;
   logic [LINE_BITS-1:0]   out_line_ff;
   logic [COLUMN_BITS-1:0] out_col_ff;
   logic                   out_last_ff;
   logic                   load, last, pop;

   assign head    = entry_ff[rd_ptr_ff];
   assign q_ready = (count_ff != CNT_BITS'(QUEUE_DEPTH));
   assign load    = (count_ff != '0) && (!valid_ff || rsp_ch.ready);
   assign last    = !(head.pair && !sel_ff);
   assign pop     = load && last;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      sel_in    = sel_ff;
      valid_in  = valid_ff;
      if (push.push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_BITS'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_BITS'(1);
      end
      if (push.push && !pop) begin
         count_in = count_ff + CNT_BITS'(1);
      end else if (pop && !push.push) begin
         count_in = count_ff - CNT_BITS'(1);
      end
      if (load) begin
         sel_in   = !last;
         valid_in = 1'b1;
      end else if (rsp_ch.ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
         sel_ff    <= 1'b0;
         valid_ff  <= 1'b0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
         sel_ff    <= sel_in;
         valid_ff  <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push.push) begin
         entry_ff[wr_ptr_ff] <= '{item0: item[0], item1: item[1],
                                 line0: item_line[0], line1: item_line[1],
                                 col0: item_col[0], col1: item_col[1],
                                 pair: push.pair};
      end
      if (load) begin
         out_item_ff <= sel_ff ? head.item1 : head.item0;
         out_line_ff <= sel_ff ? head.line1 : head.line0;
         out_col_ff  <= sel_ff ? head.col1 : head.col0;
         out_last_ff <= last;
      end
   end

   assign rsp_ch.valid       = valid_ff;
   assign rsp_ch.kind        = out_item_ff.kind;
   assign rsp_ch.text_byte   = out_item_ff.text_byte;
   assign rsp_ch.byte_valid  = out_item_ff.byte_valid;
   assign rsp_ch.token_start = out_item_ff.token_start;
   assign rsp_ch.token_end   = out_item_ff.token_end;
   assign rsp_ch.line        = out_line_ff;
   assign rsp_ch.column      = out_col_ff;
   assign rsp_ch.error       = out_item_ff.error;
   assign rsp_ch.last_of_run = out_last_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_BITS'(QUEUE_DEPTH))
      else $error("queue count beyond depth");

   a_second_half: assert property (@(posedge clock) disable iff (reset)
      sel_ff |-> (count_ff != '0 && head.pair))
      else $error("second word selected without a pair at the head");

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push.push |-> q_ready)
      else $error("push into a full queue");

endmodule

FILE: rtl/core/assembler_source_tokenizer.sv
`timescale 1ns / 1ps
// Assembler source tokenizer, top level: lexer front, word queue, output register.
// A byte's words are written into the pair queue and then loaded into the output register.
// Throughput: one byte per cycle while words leave at one per cycle; the words of
// two-word bytes build up in the four-entry pair queue, and a full queue holds the input.
// Reset: synchronous, active high; position returns to line 1, column 1, queue empties.
module assembler_source_tokenizer #(
   parameter int LINE_BITS   = asmtok_pkg::LINE_BITS_DEF,
   parameter int COLUMN_BITS = asmtok_pkg::COLUMN_BITS_DEF
) (
   input logic          clock,
   input logic          reset,
   asmtok_req_if.sink   req_ch,
   asmtok_rsp_if.source rsp_ch
);
   import asmtok_pkg::*;

   tok_push_type           push;
   tok_item_type           item [2];
   logic [LINE_BITS-1:0]   item_line [2];
   logic [COLUMN_BITS-1:0] item_col [2];
   logic                   q_ready;

   asmtok_front #(
      .LINE_BITS   (LINE_BITS),
      .COLUMN_BITS (COLUMN_BITS)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_ch),
      .q_ready   (q_ready),
      .push      (push),
      .item      (item),
      .item_line (item_line),
      .item_col  (item_col)
   );

   asmtok_back #(
      .LINE_BITS   (LINE_BITS),
      .COLUMN_BITS (COLUMN_BITS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .item      (item),
      .item_line (item_line),
      .item_col  (item_col),
      .q_ready   (q_ready),
      .rsp_ch    (rsp_ch)
   );

endmodule
